// ===== src/klnc_pkg.sv =====
// Package: token types, scanner codes and character class functions for the keyword lexer.
`timescale 1ns / 1ps
`default_nettype none

package klnc_pkg;

  localparam int MAX_WORD_LEN_DEF = 255;
  localparam int MAX_NEST_DEF     = 255;

  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_Y     = 8'h79;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_BQ    = 8'h60;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_USCR  = 8'h5f;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_WORD   = 3'd1,
    M_SLASH  = 3'd2,
    M_LINE   = 3'd3,
    M_BLOCK  = 3'd4,
    M_BSLASH = 3'd5,
    M_BSTAR  = 3'd6
  } scan_mode_t;

  typedef enum logic [3:0] {
    K_NONE  = 4'd0,
    K_V     = 4'd1,
    K_VA    = 4'd2,
    K_VAR   = 4'd3,
    K_D     = 4'd4,
    K_DE    = 4'd5,
    K_DEF   = 4'd6,
    K_P     = 4'd7,
    K_PR    = 4'd8,
    K_PRI   = 4'd9,
    K_PRIM  = 4'd10,
    K_PRO   = 4'd11,
    K_T     = 4'd12,
    K_TY    = 4'd13,
    K_TYP   = 4'd14,
    K_TDONE = 4'd15
  } kw_t;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] len;
    logic       is_end;
    logic       ovf;
    logic       last;
  } token_t;

  typedef struct packed {
    token_t     tok0;
    token_t     tok1;
    logic [1:0] count;
  } tok_pair_t;

  function automatic logic is_word_char(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]}) ||
           (c inside {CH_USCR, CH_BS, CH_BQ, CH_APOS});
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_CR, CH_LF};
  endfunction

  function automatic kw_t kw_first(input logic [7:0] c);
    kw_t k;
    case (c)
      CH_V:    k = K_V;
      CH_D:    k = K_D;
      CH_P:    k = K_P;
      CH_T:    k = K_T;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic kw_t kw_next(input kw_t k, input logic [7:0] c);
    kw_t r;
    r = K_NONE;
    case (k)
      K_V:     if (c == CH_A) r = K_VA;
      K_VA:    if (c == CH_R) r = K_VAR;
      K_D:     if (c == CH_E) r = K_DE;
      K_DE:    if (c == CH_F) r = K_DEF;
      K_P:     if (c == CH_R) r = K_PR;
      K_PR: begin
        if (c == CH_I) r = K_PRI;
        else if (c == CH_O) r = K_PRO;
      end
      K_PRI:   if (c == CH_M) r = K_PRIM;
      K_PRO:   if (c == CH_P) r = K_TDONE;
      K_T:     if (c == CH_Y) r = K_TY;
      K_TY:    if (c == CH_P) r = K_TYP;
      K_TYP:   if (c == CH_E) r = K_TDONE;
      default: r = K_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_code(input kw_t k);
    logic [7:0] r;
    case (k)
      K_VAR:   r = CH_V;
      K_DEF:   r = CH_D;
      K_PRIM:  r = CH_P;
      K_TDONE: r = CH_T;
      default: r = CH_X;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/keyword_lexer_nested_comments_unit.sv =====
// Keyword lexer with nested block comments: top level.
// Takes one character word per cycle while the result queue has room and returns tokens: keyword
// codes v, d, p, t, x for other words with their length, single punctuation characters, and an
// end token on end of input. A character that yields one token or none is taken every cycle
// while the queue has room; one that yields two (a word ended by punctuation, or a lone slash
// followed by punctuation, or a flush at end of input) takes two slots of the three-slot queue
// that the single result port drains.
`timescale 1ns / 1ps
`default_nettype none

module keyword_lexer_nested_comments_unit
  import klnc_pkg::*;
#(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
  parameter int MAX_NEST     = MAX_NEST_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      token_code,
  output logic [7:0]      word_length,
  output logic            is_end,
  output logic            overflow,
  output logic            last
);

  tok_pair_t toks;
  token_t    head;
  logic      accept;

  assign accept = in_valid & in_ready;

  klnc_core #(
    .MAX_WORD_LEN(MAX_WORD_LEN),
    .MAX_NEST    (MAX_NEST)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_code   (char_code),
    .end_of_input(end_of_input),
    .toks        (toks)
  );

  klnc_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .in_accept(accept),
    .toks     (toks),
    .room     (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign token_code  = head.code;
  assign word_length = head.len;
  assign is_end      = head.is_end;
  assign overflow    = head.ovf;
  assign last        = head.last;

endmodule

`default_nettype wire

// ===== src/klnc_core.sv =====
// Scanner state and per-character token logic.
`timescale 1ns / 1ps
`default_nettype none

module klnc_core
  import klnc_pkg::*;
#(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
  parameter int MAX_NEST     = MAX_NEST_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_input,
  output tok_pair_t       toks
);

  localparam int NestW = $clog2(MAX_NEST + 1);
  localparam logic [7:0] LenLimit = (MAX_WORD_LEN < 255) ? 8'(MAX_WORD_LEN) : 8'd255;
  localparam logic [NestW-1:0] NestMax = NestW'(MAX_NEST);

  scan_mode_t       mode, mode_next;
  kw_t              kw, kw_next_q;
  logic [7:0]       word_count, word_count_next;
  logic             word_ovf, word_ovf_next;
  logic [NestW-1:0] nest_depth, nest_depth_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      kw         <= K_NONE;
      word_count <= '0;
      word_ovf   <= 1'b0;
      nest_depth <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      kw         <= kw_next_q;
      word_count <= word_count_next;
      word_ovf   <= word_ovf_next;
      nest_depth <= nest_depth_next;
    end
  end

  always_comb begin
    token_t           t0, t1, e;
    logic [1:0]       n;
    logic             do_idle;
    logic             do_emit;
    logic [NestW-1:0] dec;

    mode_next       = mode;
    kw_next_q       = kw;
    word_count_next = word_count;
    word_ovf_next   = word_ovf;
    nest_depth_next = nest_depth;
    t0      = '0;
    t1      = '0;
    n       = 2'd0;
    do_idle = 1'b0;
    do_emit = 1'b0;
    e       = '0;
    dec     = (nest_depth != '0) ? nest_depth - NestW'(1) : '0;

    if (end_of_input) begin
      if (mode == M_WORD) begin
        t0 = '{code: kw_code(kw), len: word_count, is_end: 1'b0, ovf: word_ovf, last: 1'b0};
        n  = 2'd1;
      end else if (mode == M_SLASH) begin
        t0 = '{code: CH_SLASH, len: 8'd1, is_end: 1'b0, ovf: 1'b0, last: 1'b0};
        n  = 2'd1;
      end
      e = '{code: 8'd0, len: 8'd0, is_end: 1'b1, ovf: 1'b0, last: 1'b0};
      if (n == 2'd0) t0 = e;
      else t1 = e;
      n               = n + 2'd1;
      mode_next       = M_IDLE;
      kw_next_q       = K_NONE;
      word_count_next = '0;
      word_ovf_next   = 1'b0;
      nest_depth_next = '0;
    end else begin
      case (mode)
        M_WORD: begin
          if (is_word_char(char_code)) begin
            if (word_count < LenLimit) word_count_next = word_count + 8'd1;
            else word_ovf_next = 1'b1;
            kw_next_q = kw_next(kw, char_code);
          end else begin
            t0 = '{code: kw_code(kw), len: word_count, is_end: 1'b0, ovf: word_ovf,
                   last: 1'b0};
            n               = 2'd1;
            word_count_next = '0;
            kw_next_q       = K_NONE;
            word_ovf_next   = 1'b0;
            do_idle         = 1'b1;
          end
        end
        M_SLASH: begin
          if (char_code == CH_SLASH) begin
            mode_next = M_LINE;
          end else if (char_code == CH_STAR) begin
            nest_depth_next = NestW'(1);
            mode_next       = M_BLOCK;
          end else begin
            t0      = '{code: CH_SLASH, len: 8'd1, is_end: 1'b0, ovf: 1'b0, last: 1'b0};
            n       = 2'd1;
            do_idle = 1'b1;
          end
        end
        M_LINE: begin
          if (char_code == CH_LF) mode_next = M_IDLE;
        end
        M_BLOCK: begin
          if (char_code == CH_SLASH) mode_next = M_BSLASH;
          else if (char_code == CH_STAR) mode_next = M_BSTAR;
        end
        M_BSLASH: begin
          if (char_code != CH_SLASH) begin
            if (char_code == CH_STAR && nest_depth < NestMax)
              nest_depth_next = nest_depth + NestW'(1);
            mode_next = M_BLOCK;
          end
        end
        M_BSTAR: begin
          if (char_code != CH_STAR) begin
            mode_next = M_BLOCK;
            if (char_code == CH_SLASH) begin
              nest_depth_next = dec;
              if (dec == '0) mode_next = M_IDLE;
            end
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        if (is_blank(char_code)) begin
          mode_next = M_IDLE;
        end else if (char_code == CH_HASH || char_code == CH_PCT) begin
          mode_next = M_LINE;
        end else if (char_code == CH_SLASH) begin
          mode_next = M_SLASH;
        end else if (is_word_char(char_code)) begin
          mode_next       = M_WORD;
          word_count_next = 8'd1;
          word_ovf_next   = 1'b0;
          kw_next_q       = kw_first(char_code);
        end else begin
          mode_next = M_IDLE;
          do_emit   = 1'b1;
        end
      end

      if (do_emit) begin
        e = '{code: char_code, len: 8'd1, is_end: 1'b0, ovf: 1'b0, last: 1'b0};
        if (n == 2'd0) t0 = e;
        else t1 = e;
        n = n + 2'd1;
      end
    end

    if (n == 2'd1) t0.last = 1'b1;
    if (n == 2'd2) t1.last = 1'b1;
    toks = '{tok0: t0, tok1: t1, count: n};
  end

  a_word_len: assert property (@(posedge clk) disable iff (rst)
    (mode == M_WORD) |-> (word_count != 8'd0))
    else $error("word mode with empty word");

  a_word_clear: assert property (@(posedge clk) disable iff (rst)
    (mode != M_WORD) |-> (word_count == 8'd0 && !word_ovf && kw == K_NONE))
    else $error("word state left behind outside a word");

  a_nest: assert property (@(posedge clk) disable iff (rst)
    (mode == M_BLOCK || mode == M_BSLASH || mode == M_BSTAR) == (nest_depth != '0))
    else $error("nesting depth disagrees with comment mode");

endmodule

`default_nettype wire

// ===== src/klnc_obuf.sv =====
// Three-slot shifting result queue that takes up to two tokens per word.
`timescale 1ns / 1ps
`default_nettype none

module klnc_obuf
  import klnc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_accept,
  input  tok_pair_t toks,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output token_t    head
);

  localparam int Depth = 3;

  token_t     q [Depth];
  token_t     q_next [Depth];
  logic [1:0] cnt, cnt_next;
  logic [1:0] cap;
  logic [1:0] push_n;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign head      = q[0];
  assign pop       = out_valid & out_ready;
  assign cap       = cnt - {1'b0, pop};
  assign room      = (cap <= 2'd1);
  assign push_n    = in_accept ? toks.count : 2'd0;
  assign cnt_next  = cap + push_n;

  always_comb begin
    token_t sh;
    for (int i = 0; i < Depth; i++) begin
      sh = (pop && i < Depth - 1) ? q[(i < Depth - 1) ? i + 1 : i] : q[i];
      if (2'(i) == cap && push_n != 2'd0) q_next[i] = toks.tok0;
      else if (2'(i) == cap + 2'd1 && push_n == 2'd2) q_next[i] = toks.tok1;
      else q_next[i] = sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else cnt <= cnt_next;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) q[i] <= q_next[i];
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= 2'(Depth))
    else $error("queue count beyond depth");

  a_room: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> (cap + toks.count <= 2'(Depth)))
    else $error("word taken without room for its tokens");

endmodule

`default_nettype wire
